// ===== sv/pefu_pkg.sv =====
// ----------------------------------------------------------------------------
// pefu_pkg
// Shared types and constants for the power estimate feedback update block.
// ----------------------------------------------------------------------------
`default_nettype none

package pefu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;

    localparam logic [1:0] REG_BASE_POWER = 2'd0;
    localparam logic [1:0] REG_BASE_COV   = 2'd1;
    localparam logic [1:0] REG_IDLE_POWER = 2'd2;
    localparam logic [1:0] REG_IDLE_COV   = 2'd3;
    localparam int         NUM_REGS       = 4;

    typedef struct packed {
        logic signed [DW-1:0] app_power;
        logic signed [DW-1:0] app_cov;
        logic signed [DW-1:0] radio_power;
        logic signed [DW-1:0] radio_cov;
        logic signed [DW-1:0] feedback_power;
        logic signed [DW-1:0] feedback_cov;
    } in_item_t;

    typedef struct packed {
        logic signed [DW-1:0] total_power;
        logic signed [DW-1:0] new_app_power;
        logic signed [DW-1:0] new_app_cov;
        logic signed [DW-1:0] new_radio_power;
        logic signed [DW-1:0] new_radio_cov;
        logic                 zero_confidence;
    } out_item_t;

endpackage

`default_nettype wire

// ===== sv/power_estimate_feedback_update.sv =====
// ----------------------------------------------------------------------------
// power_estimate_feedback_update
// Kalman-style feedback update of four power estimates, one transaction at a
// time, using a bit-serial multiplier and a restoring bit-serial divider.
// ----------------------------------------------------------------------------
// A transaction whose confidence is zero skips the gains and the updates.
// Every product goes through a shift-add multiplier that retires one
// multiplier bit per cycle, with a step each to load it, fix its sign and
// consume it; a full item has 12 products. Each of the four gains goes through
// a restoring divider that retires one quotient bit per cycle, with a step to
// load it and one to unload it. The total, the confidence and the updates are
// saturating sums, each registered in its own state. The result is held in a
// register, and a new transaction is taken only once the result has been
// taken. Writes to the init registers load the matching base or idle state at
// once and must happen while idle.
`default_nettype none

module power_estimate_feedback_update (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pefu_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pefu_pkg::out_item_t       out_data,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_wdata
);
    import pefu_pkg::*;

    localparam logic signed [63:0] SMAX = 64'sd2147483647;
    localparam logic signed [63:0] SMIN = -64'sd2147483648;

    typedef enum logic [3:0] {
        S_IDLE, S_TOTAL, S_MSTART, S_MUL, S_MDONE, S_CONF, S_DSTART,
        S_DIV, S_DDONE, S_UPD, S_OUT
    } state_t;

    // step within the item: 0 for the products, 16..17 per-source updates
    state_t            state_reg;
    logic [4:0]        step_reg;
    logic [1:0]        src_reg;
    logic [5:0]        cnt_reg;

    logic signed [DW-1:0] pw_reg [4];
    logic signed [DW-1:0] cv_reg [4];
    logic signed [DW-1:0] pr_reg [4];
    logic signed [DW-1:0] fbp_reg, fbc_reg, conf_reg, gain_reg, tot_reg, gfb_reg;
    logic                 zero_reg;

    // serial multiplier: acc holds running sum, mplr shifts out one bit
    logic signed [64:0] macc_reg;
    logic signed [64:0] mcand_reg;
    logic [31:0]        mplr_reg;
    logic               mneg_reg;

    // serial divider on magnitudes
    logic [63:0] dnum_reg;
    logic [64:0] drem_reg;
    logic [31:0] dden_reg;
    logic        dneg_reg;

    logic signed [63:0] mul_res;
    logic signed [DW-1:0] mul_sat;
    logic [64:0] rem_try;
    logic signed [64:0] qs;
    logic signed [DW-1:0] div_sat;
    logic signed [DW-1:0] mul_a, mul_b;

    function automatic logic signed [DW-1:0] sat(input logic signed [63:0] v);
        if (v > SMAX) return SMAX[DW-1:0];
        if (v < SMIN) return SMIN[DW-1:0];
        return v[DW-1:0];
    endfunction

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = cv_reg[src_reg];
        mul_b = pw_reg[src_reg];
        if (step_reg[4]) begin
            unique case (step_reg[1:0])
                2'd0:    begin mul_a = gain_reg; mul_b = fbp_reg; end
                default: begin mul_a = gain_reg; mul_b = cv_reg[src_reg]; end
            endcase
        end
    end

    // floor shift of the exact product, then saturation
    assign mul_res = 64'(macc_reg >>> FRAC_BITS);
    assign mul_sat = sat(mul_res);
    assign rem_try = {drem_reg[63:0], dnum_reg[63]} - {33'd0, dden_reg};
    assign qs      = dneg_reg ? -$signed({1'b0, dnum_reg}) : $signed({1'b0, dnum_reg});
    assign div_sat = (qs > 65'(SMAX)) ? SMAX[DW-1:0] :
                     (qs < 65'(SMIN)) ? SMIN[DW-1:0] : qs[DW-1:0];

    assign in_ready  = (state_reg == S_IDLE) && !out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
            step_reg  <= '0;
            src_reg   <= '0;
            cnt_reg   <= '0;
            for (int i = 0; i < 2; i++) begin
                pw_reg[i] <= '0;
                cv_reg[i] <= '0;
            end
        end else begin
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_BASE_POWER: pw_reg[0] <= cfg_wdata;
                    REG_BASE_COV:   cv_reg[0] <= cfg_wdata;
                    REG_IDLE_POWER: pw_reg[1] <= cfg_wdata;
                    REG_IDLE_COV:   cv_reg[1] <= cfg_wdata;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid && in_ready) begin
                        pw_reg[2] <= in_data.app_power;
                        cv_reg[2] <= in_data.app_cov;
                        pw_reg[3] <= in_data.radio_power;
                        cv_reg[3] <= in_data.radio_cov;
                        fbp_reg   <= in_data.feedback_power;
                        fbc_reg   <= in_data.feedback_cov;
                        state_reg <= S_TOTAL;
                    end
                end
                S_TOTAL: begin
                    tot_reg <= sat(64'(pw_reg[0]) + 64'(pw_reg[1])
                                 + 64'(pw_reg[2]) + 64'(pw_reg[3]));
                    step_reg  <= '0;
                    src_reg   <= '0;
                    state_reg <= S_MSTART;
                end
                // load multiplier: magnitude of b is shifted bit by bit
                S_MSTART: begin
                    macc_reg  <= '0;
                    mcand_reg <= 65'(mul_a);
                    mplr_reg  <= mul_b[DW-1] ? 32'(-mul_b) : mul_b;
                    mneg_reg  <= mul_b[DW-1];
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    if (mplr_reg[0])
                        macc_reg <= macc_reg + mcand_reg;
                    mcand_reg <= mcand_reg <<< 1;
                    mplr_reg  <= mplr_reg >> 1;
                    cnt_reg   <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31)
                        state_reg <= S_MDONE;
                end
                S_MDONE: begin
                    if (mneg_reg)
                        macc_reg <= -macc_reg;
                    state_reg <= S_CONF;
                end
                // consume a product
                S_CONF: begin
                    if (!step_reg[4]) begin
                        pr_reg[src_reg] <= mul_sat;
                        src_reg <= src_reg + 2'd1;
                        if (src_reg == 2'd3) begin
                            step_reg  <= 5'd8;
                            state_reg <= S_UPD;
                        end else begin
                            state_reg <= S_MSTART;
                        end
                    end else if (step_reg[1:0] == 2'd0) begin
                        gfb_reg   <= mul_sat;
                        step_reg  <= step_reg + 5'd1;
                        state_reg <= S_MSTART;
                    end else begin
                        pw_reg[src_reg] <= sat(64'(pw_reg[src_reg]) + 64'(gfb_reg));
                        cv_reg[src_reg] <= sat(64'(cv_reg[src_reg]) - 64'(mul_sat));
                        src_reg <= src_reg + 2'd1;
                        step_reg <= 5'd16;
                        state_reg <= (src_reg == 2'd3) ? S_OUT : S_DSTART;
                    end
                end
                S_UPD: begin
                    conf_reg <= sat(64'(pr_reg[0]) + 64'(pr_reg[1]) + 64'(pr_reg[2])
                                  + 64'(pr_reg[3]) + 64'(fbc_reg));
                    step_reg  <= 5'd16;
                    src_reg   <= '0;
                    state_reg <= S_DSTART;
                end
                // divide (prod << FRAC_BITS) by confidence, toward zero
                S_DSTART: begin
                    if (conf_reg == '0) begin
                        zero_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        zero_reg <= 1'b0;
                        dnum_reg <= 64'(pr_reg[src_reg][DW-1] ?
                                    -64'(pr_reg[src_reg]) : 64'(pr_reg[src_reg]))
                                    << FRAC_BITS;
                        dden_reg <= conf_reg[DW-1] ? 32'(-conf_reg) : conf_reg;
                        dneg_reg <= pr_reg[src_reg][DW-1] ^ conf_reg[DW-1];
                        drem_reg <= '0;
                        cnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!rem_try[64]) begin
                        drem_reg <= rem_try;
                        dnum_reg <= {dnum_reg[62:0], 1'b1};
                    end else begin
                        drem_reg <= {drem_reg[63:0], dnum_reg[63]};
                        dnum_reg <= {dnum_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                        state_reg <= S_DDONE;
                end
                S_DDONE: begin
                    gain_reg  <= div_sat;
                    step_reg  <= 5'd16;
                    state_reg <= S_MSTART;
                end
                S_OUT: begin
                    out_data.total_power     <= tot_reg;
                    out_data.new_app_power   <= pw_reg[2];
                    out_data.new_app_cov     <= cv_reg[2];
                    out_data.new_radio_power <= pw_reg[3];
                    out_data.new_radio_cov   <= cv_reg[3];
                    out_data.zero_confidence <= zero_reg;
                    out_valid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for power_estimate_feedback_update: a directed table of
// corner transactions, then random ones, each result compared as a whole against
// a fixed-point predictor of the estimate and covariance update, or a typed-in value.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pefu_pkg::*;

    localparam int  N_RANDOM     = 1400;
    localparam int  WATCHDOG_MAX = 20000;
    localparam int  DRAIN_CYCLES = 1000;
    localparam longint S32_MAX   = 64'sd2147483647;
    localparam longint S32_MIN   = -64'sd2147483648;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    power_estimate_feedback_update u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state: base and idle estimates
    longint est_base_pw, est_base_cv, est_idle_pw, est_idle_cv;

    out_item_t expected_updates[$];
    int  mismatches;
    int  n_sent;
    int  n_checked;
    int  n_zero_conf;
    int  idle_cycles;

    // directed table; expected typed in only where obvious
    typedef struct {
        in_item_t  stim;
        bit        has_known;
        out_item_t known;
    } dir_row_t;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sat32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // exact product, shift with floor (>>> on signed is floor), saturate
    function automatic longint qmul(longint a, longint b);
        return sat32((a * b) >>> FRAC_BITS);
    endfunction

    function automatic longint qgain(longint prod, longint conf);
        longint num;
        num = prod * (64'sd1 <<< FRAC_BITS);
        return sat32(num / conf);
    endfunction

    function automatic void apply_gain(inout longint pw, inout longint cv,
                                       input longint prod, input longint conf,
                                       input longint fb);
        longint g;
        longint old_cv;
        g = qgain(prod, conf);
        old_cv = cv;
        pw = sat32(pw + qmul(g, fb));
        cv = sat32(old_cv - qmul(g, old_cv));
    endfunction

    // feedback update of all four sources; advances the base/idle state
    function automatic out_item_t predict_update(in_item_t it);
        out_item_t r;
        longint ap, ac, rp, rc, fb, fc, pb, pi, pa, pr, conf, total;
        ap = longint'(it.app_power);
        ac = longint'(it.app_cov);
        rp = longint'(it.radio_power);
        rc = longint'(it.radio_cov);
        fb = longint'(it.feedback_power);
        fc = longint'(it.feedback_cov);
        total = sat32(est_idle_pw + est_base_pw + ap + rp);
        pb = qmul(est_base_cv, est_base_pw);
        pi = qmul(est_idle_cv, est_idle_pw);
        pa = qmul(ac, ap);
        pr = qmul(rc, rp);
        conf = sat32(pb + pi + pa + pr + fc);
        r.zero_confidence = (conf == 0);
        if (conf != 0)
        begin
            apply_gain(est_base_pw, est_base_cv, pb, conf, fb);
            apply_gain(est_idle_pw, est_idle_cv, pi, conf, fb);
            apply_gain(ap, ac, pa, conf, fb);
            apply_gain(rp, rc, pr, conf, fb);
        end
        r.total_power     = total[31:0];
        r.new_app_power   = ap[31:0];
        r.new_app_cov     = ac[31:0];
        r.new_radio_power = rp[31:0];
        r.new_radio_cov   = rc[31:0];
        return r;
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 8)) - 4);
            3: return $urandom;
            default: return 32'(int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it.app_power      = rand_q();
        it.app_cov        = rand_q();
        it.radio_power    = rand_q();
        it.radio_cov      = rand_q();
        it.feedback_power = rand_q();
        it.feedback_cov   = rand_q();
        // now and then cancel the confidence sum
        if ($urandom_range(0, 15) == 0)
        begin
            it.app_cov   = '0;
            it.radio_cov = '0;
            it.feedback_cov = 32'(-(qmul(est_base_cv, est_base_pw)
                                  + qmul(est_idle_cv, est_idle_pw)));
        end
        return it;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_BASE_POWER: est_base_pw = longint'(signed'(val));
            REG_BASE_COV:   est_base_cv = longint'(signed'(val));
            REG_IDLE_POWER: est_idle_pw = longint'(signed'(val));
            default:        est_idle_cv = longint'(signed'(val));
        endcase
    endtask

    // drop valid and wait for the pipeline to empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_updates.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // valid stays up after acceptance until the next item or an idle gap
    task automatic send(input in_item_t it, input bit has_known, input out_item_t known);
        out_item_t pred;
        int        n_idle;
        n_idle = $urandom_range(0, 13);
        if (n_idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (n_idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pred = predict_update(it);
        if (has_known && pred != known)
            $display("directed row disagrees with predictor: %h vs %h", known, pred);
        expected_updates.push_back(has_known ? known : pred);
        n_sent++;
    endtask

    // result checker and receiver stalls
    initial
    begin
        out_item_t exp_r;
        int stall;
        out_ready = 1'b0;
        mismatches = 0;
        n_checked = 0;
        n_zero_conf = 0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_updates.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", out_data);
                end
                else
                begin
                    exp_r = expected_updates.pop_front();
                    n_checked++;
                    if (exp_r.zero_confidence) n_zero_conf++;
                    if (out_data !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: total %h/%h app %h %h/%h %h radio %h %h/%h %h zc %b/%b",
                                exp_r.total_power, out_data.total_power,
                                exp_r.new_app_power, exp_r.new_app_cov,
                                out_data.new_app_power, out_data.new_app_cov,
                                exp_r.new_radio_power, exp_r.new_radio_cov,
                                out_data.new_radio_power, out_data.new_radio_cov,
                                exp_r.zero_confidence, out_data.zero_confidence);
                    end
                end
                stall = $urandom_range(0, 13);
                if ($urandom_range(0, 3) == 0) stall = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted transaction or taken result
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        dir_row_t  rows[$];
        dir_row_t  row;
        out_item_t none;
        int        phase;
        int        k;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_BASE_POWER;
        cfg_wdata = '0;
        est_base_pw = 0; est_base_cv = 0; est_idle_pw = 0; est_idle_cv = 0;
        n_sent = 0;
        none = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero after reset: zero confidence, fields pass through
        row.stim = '0; row.has_known = 1'b1; row.known = '0;
        row.known.zero_confidence = 1'b1;
        rows.push_back(row);
        // positive/negative extremes, still zero confidence (no covariance)
        row.stim = '{32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0};
        row.known = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 1'b1};
        rows.push_back(row);
        row.stim = '{32'h8000_0000, 0, 32'h8000_0000, 0, 32'h8000_0000, 0};
        row.known = '{32'h8000_0000, 32'h8000_0000, 0, 32'h8000_0000, 0, 1'b1};
        rows.push_back(row);
        row.has_known = 1'b0;
        row.known = none;
        // gain of exactly one, saturating products, negative confidence
        row.stim = '{32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0002_0000, 0};
        rows.push_back(row);
        row.stim = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF};
        rows.push_back(row);
        row.stim = '{32'hFFFF_0000, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000,
                     32'h8000_0000, 32'hFFFF_FFFF};
        rows.push_back(row);
        row.stim = '{32'h0000_0001, 32'h0000_0001, 0, 0, 32'h7FFF_FFFF, 32'h0000_0001};
        rows.push_back(row);
        row.stim = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF};
        rows.push_back(row);
        for (k = 0; k < rows.size(); k++)
            send(rows[k].stim, rows[k].has_known, rows[k].known);

        // random phases, each with new init registers (extremes included)
        for (phase = 0; phase < 7; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    write_reg(REG_BASE_POWER, 32'h0001_0000);
                    write_reg(REG_BASE_COV,   32'h0000_8000);
                    write_reg(REG_IDLE_POWER, 32'h0000_4000);
                    write_reg(REG_IDLE_COV,   32'h0002_0000);
                end
                1:
                begin
                    write_reg(REG_BASE_POWER, 32'h7FFF_FFFF);
                    write_reg(REG_BASE_COV,   32'h7FFF_FFFF);
                    write_reg(REG_IDLE_POWER, 32'h8000_0000);
                    write_reg(REG_IDLE_COV,   32'h8000_0000);
                end
                2:
                begin
                    write_reg(REG_BASE_POWER, 32'h8000_0000);
                    write_reg(REG_BASE_COV,   32'h7FFF_FFFF);
                    write_reg(REG_IDLE_POWER, 32'h7FFF_FFFF);
                    write_reg(REG_IDLE_COV,   32'hFFFF_FFFF);
                end
                3:
                begin
                    write_reg(REG_BASE_POWER, '0);
                    write_reg(REG_BASE_COV,   '0);
                    write_reg(REG_IDLE_POWER, '0);
                    write_reg(REG_IDLE_COV,   '0);
                end
                default:
                begin
                    write_reg(REG_BASE_POWER, rand_q());
                    write_reg(REG_BASE_COV,   rand_q());
                    write_reg(REG_IDLE_POWER, rand_q());
                    write_reg(REG_IDLE_COV,   rand_q());
                end
            endcase
            for (k = 0; k < N_RANDOM / 7; k++)
            begin
                // hold off until everything has drained, once per phase
                if (k == 50) wait_idle();
                send(rand_item(), 1'b0, none);
            end
        end

        // drain
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d transactions (%0d checked, %0d with zero confidence)",
                 n_sent, n_checked, n_zero_conf);
        $display("init registers swept over 7 settings incl. both saturation limits");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/pefu_pkg.sv
sv/power_estimate_feedback_update.sv
tb/tb.sv
